/* hdl/text_terminal_char_engine_defines.svh */
// Assertion macros shared by the text terminal character engine.
`ifndef TEXT_TERMINAL_CHAR_ENGINE_DEFINES_SVH
`define TEXT_TERMINAL_CHAR_ENGINE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define TTCE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TTCE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TTCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ttce_pkg.sv */
// Package of constants, types and address helpers for the text terminal character engine.
`default_nettype none

package ttce_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int TAB_STOP   = 4;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int SUM_W  = ADDR_W + 1;
    localparam int TAB_W  = $clog2(TAB_STOP) + 1;
    localparam int CELL_W = 16;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [CELL_W-1:0] t_cell;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TAB,
        ST_BLANK,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        REQ_PUT  = 2'd0,
        REQ_MOVE = 2'd1,
        REQ_READ = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam t_cell      RESET_CELL  = 16'h0720;
    localparam logic [7:0] RESET_COLOR = 8'h07;

    localparam t_addr LAST_ADDR = t_addr'(CELL_COUNT - 1);
    localparam t_addr COLS_ADDR = t_addr'(COLUMNS);
    localparam t_col  COL_LAST  = t_col'(COLUMNS - 1);
    localparam t_row  ROW_LAST  = t_row'(ROWS - 1);

    // a + b modulo CELL_COUNT, with a and b both below CELL_COUNT
    function automatic t_addr wrap_add(t_addr a, t_addr b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(CELL_COUNT)) begin
            s = s - SUM_W'(CELL_COUNT);
        end
        return s[ADDR_W-1:0];
    endfunction

    // a - b modulo CELL_COUNT
    function automatic t_addr wrap_sub(t_addr a, t_addr b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(CELL_COUNT) - SUM_W'(b);
        if (a >= b) begin
            s = SUM_W'(a) - SUM_W'(b);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/ttce_ram.sv */
// Simple dual-port screen RAM with registered read.
`default_nettype none

module ttce_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/text_terminal_char_engine.sv */
// Text terminal character engine top level: cursor sequencer around the screen RAM.
//
// The screen lives in one RAM of ROWS x COLUMNS 16-bit cells used as a ring of rows, so a
// scroll moves a row offset instead of copying. After reset the block runs a clearing pass
// over all CELL_COUNT (2000) cells, writing grey spaces, and accepts no request until it ends.
// A tab makes one RAM write per padded cell. Any scroll blanks the new bottom row, COLUMNS
// (80) cells, through the single RAM write port. The result is held in an output register,
// so the next request is taken while it waits.
`default_nettype none

module text_terminal_char_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [7:0]                 i_text_color,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [7:0]                 i_char_code,
    input  logic [1:0]                 i_move_dir,
    input  logic [10:0]                i_cell_index,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [4:0]                 o_cursor_row,
    output logic [6:0]                 o_cursor_col,
    output logic [ttce_pkg::CELL_W-1:0] o_cell_data
);

    `include "text_terminal_char_engine_defines.svh"

    import ttce_pkg::*;

    t_state           r_state, n_state;
    t_row             r_row, n_row;
    t_col             r_col, n_col;
    t_addr            r_pcur, n_pcur;
    t_addr            r_base, n_base;
    t_addr            r_clr, n_clr;
    t_addr            r_bptr, n_bptr;
    t_col             r_bcnt, n_bcnt;
    logic [TAB_W-1:0] r_cnt, n_cnt;
    logic             r_tab_ret, n_tab_ret;
    logic             r_rd, n_rd;
    logic [7:0]       r_color;
    logic             r_out_valid, n_out_valid;
    logic [4:0]       r_out_row, n_out_row;
    logic [6:0]       r_out_col, n_out_col;
    t_cell            r_out_data, n_out_data;

    logic             mem_we;
    t_addr            mem_waddr;
    t_cell            mem_wdata;
    logic             mem_re;
    t_addr            mem_raddr;
    t_cell            mem_rdata;

    logic             col_last;
    logic             row_last;
    t_col             adv_col;
    t_row             adv_row;
    logic             adv_scroll;
    t_addr            pcur_inc;
    t_addr            pcur_dec;
    t_addr            base_next;
    logic             do_adv;
    logic             do_scroll;

    ttce_ram #(
        .DEPTH (CELL_COUNT),
        .WIDTH (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_cell_data  = r_out_data;

    assign col_last   = (r_col == COL_LAST);
    assign row_last   = (r_row == ROW_LAST);
    assign adv_col    = col_last ? '0 : r_col + 1'b1;
    assign adv_row    = (col_last && !row_last) ? r_row + 1'b1 : r_row;
    assign adv_scroll = col_last && row_last;
    assign pcur_inc   = wrap_add(r_pcur, t_addr'(1));
    assign pcur_dec   = wrap_sub(r_pcur, t_addr'(1));
    assign base_next  = wrap_add(r_base, COLS_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= RESET_COLOR;
        end else if (i_cfg_valid) begin
            r_color <= i_text_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_pcur      <= '0;
            r_base      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pcur      <= n_pcur;
            r_base      <= n_base;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bptr     <= n_bptr;
        r_bcnt     <= n_bcnt;
        r_cnt      <= n_cnt;
        r_tab_ret  <= n_tab_ret;
        r_rd       <= n_rd;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_pcur      = r_pcur;
        n_base      = r_base;
        n_clr       = r_clr;
        n_bptr      = r_bptr;
        n_bcnt      = r_bcnt;
        n_cnt       = r_cnt;
        n_tab_ret   = r_tab_ret;
        n_rd        = r_rd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = r_pcur;
        mem_wdata   = {r_color, CH_SPACE};
        mem_re      = 1'b0;
        mem_raddr   = r_pcur;
        do_adv      = 1'b0;
        do_scroll   = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = RESET_CELL;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_rd      = 1'b0;
                    n_tab_ret = 1'b0;
                    n_state   = ST_DONE;
                    case (i_req_type)
                        REQ_PUT: begin
                            case (i_char_code)
                                CH_NL: begin
                                    n_col  = '0;
                                    n_pcur = wrap_add(r_pcur, COLS_ADDR - t_addr'(r_col));
                                    if (row_last) begin
                                        do_scroll = 1'b1;
                                    end else begin
                                        n_row = r_row + 1'b1;
                                    end
                                end
                                CH_TAB: begin
                                    n_cnt   = TAB_W'(TAB_STOP) - {1'b0, r_col[TAB_W-2:0]};
                                    n_state = ST_TAB;
                                end
                                CH_BS: begin
                                    if (r_col != '0) begin
                                        n_col     = r_col - 1'b1;
                                        n_pcur    = pcur_dec;
                                        mem_we    = 1'b1;
                                        mem_waddr = pcur_dec;
                                    end else if (r_row != '0) begin
                                        n_row     = r_row - 1'b1;
                                        n_col     = COL_LAST;
                                        n_pcur    = pcur_dec;
                                        mem_we    = 1'b1;
                                        mem_waddr = pcur_dec;
                                    end
                                end
                                default: begin
                                    mem_we    = 1'b1;
                                    mem_wdata = {r_color, i_char_code};
                                    do_adv    = 1'b1;
                                end
                            endcase
                        end
                        REQ_MOVE: begin
                            case (i_move_dir)
                                DIR_UP: begin
                                    if (r_row != '0) begin
                                        n_row  = r_row - 1'b1;
                                        n_pcur = wrap_sub(r_pcur, COLS_ADDR);
                                    end
                                end
                                DIR_DOWN: begin
                                    if (!row_last) begin
                                        n_row  = r_row + 1'b1;
                                        n_pcur = wrap_add(r_pcur, COLS_ADDR);
                                    end
                                end
                                DIR_LEFT: begin
                                    if (r_col != '0) begin
                                        n_col  = r_col - 1'b1;
                                        n_pcur = pcur_dec;
                                    end
                                end
                                default: begin
                                    if (!col_last) begin
                                        n_col  = r_col + 1'b1;
                                        n_pcur = pcur_inc;
                                    end
                                end
                            endcase
                        end
                        REQ_READ: begin
                            if (32'(i_cell_index) < 32'(CELL_COUNT)) begin
                                mem_re    = 1'b1;
                                mem_raddr = wrap_add(t_addr'(i_cell_index), r_base);
                                n_rd      = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TAB: begin
                mem_we    = 1'b1;
                do_adv    = 1'b1;
                n_cnt     = r_cnt - 1'b1;
                n_tab_ret = (r_cnt != TAB_W'(1));
                if (r_cnt == TAB_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = r_bptr;
                n_bptr    = r_bptr + 1'b1;
                n_bcnt    = r_bcnt + 1'b1;
                if (r_bcnt == COL_LAST) begin
                    n_state = r_tab_ret ? ST_TAB : ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_row   = 5'(32'(r_row));
                    n_out_col   = 7'(32'(r_col));
                    n_out_data  = r_rd ? mem_rdata : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (do_adv) begin
            n_col     = adv_col;
            n_row     = adv_row;
            n_pcur    = pcur_inc;
            do_scroll = adv_scroll;
        end

        // the new bottom row is the old top row of the ring
        if (do_scroll) begin
            n_base  = base_next;
            n_bptr  = r_base;
            n_bcnt  = '0;
            n_state = ST_BLANK;
        end
    end

    `TTCE_ASSERT_ALWAYS(a_cursor_range, (r_row <= ROW_LAST) && (r_col <= COL_LAST), "cursor off screen")
    `TTCE_ASSERT_ALWAYS(a_addr_range, (r_pcur <= LAST_ADDR) && (r_base <= LAST_ADDR), "screen address out of range")
    `TTCE_ASSERT_ALWAYS(a_no_rw_overlap, !(mem_we && mem_re), "RAM read and write in one cycle")
    `TTCE_ASSERT_IMPL(a_tab_count, r_state == ST_TAB, (r_cnt != '0) && (r_cnt <= TAB_W'(TAB_STOP)), "tab count out of range")
    `TTCE_ASSERT_NEXT(a_read_done, mem_re, r_state == ST_DONE, "read data not captured")

endmodule

`default_nettype wire

/* tb/text_terminal_char_engine_tb.sv */
// Self-checking testbench for the text terminal character engine: directed steps, then random phases under several colours.
module text_terminal_char_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttce_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         N_OPENING    = 23;
    localparam int         N_PHASES     = 6;
    localparam int         PHASE_ITEMS  = 222;
    localparam int         SETTLE_TICKS = 100;
    localparam int         HOLD_AFTER   = 500;
    localparam int         HOLD_TICKS   = 400;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [1:0]  dir;
        logic [10:0] idx;
    } request_beat_t;

    typedef struct packed {
        t_row  row;
        t_col  col;
        t_cell data;
    } screen_reply_t;

    typedef struct packed {
        request_beat_t rq;
        bit            checked;
        screen_reply_t reply;
    } opening_step_t;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_cfg_valid  = 1'b0;
    logic                o_cfg_ready;
    logic [7:0]          i_text_color = 8'h00;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_req_type   = 2'd0;
    logic [7:0]          i_char_code  = 8'h00;
    logic [1:0]          i_move_dir   = 2'd0;
    logic [10:0]         i_cell_index = 11'd0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [4:0]          o_cursor_row;
    logic [6:0]          o_cursor_col;
    logic [CELL_W-1:0]   o_cell_data;

    t_cell         screen_model [CELL_COUNT];
    t_row          cur_row;
    t_col          cur_col;
    logic [7:0]    pen_color;
    screen_reply_t pending_replies [$];
    int            fault_count = 0;
    int            items_sent  = 0;
    bit            steady_flow = 1'b0;

    opening_step_t opening_steps [N_OPENING] = '{
        '{'{REQ_READ, 8'h00, DIR_UP, 11'd0},       1'b1, '{5'd0, 7'd0, RESET_CELL}},
        '{'{REQ_READ, 8'h00, DIR_UP, LAST_ADDR},   1'b1, '{5'd0, 7'd0, RESET_CELL}},
        '{'{REQ_READ, 8'h00, DIR_UP, 11'd2000},    1'b1, '{5'd0, 7'd0, 16'h0000}},
        '{'{REQ_READ, 8'hFF, DIR_RIGHT, 11'h7FF},  1'b1, '{5'd0, 7'd0, 16'h0000}},
        '{'{REQ_UNUSED, 8'hFF, DIR_RIGHT, 11'd0},  1'b1, '{5'd0, 7'd0, 16'h0000}},
        '{'{REQ_PUT, CH_BS, DIR_UP, 11'd0},        1'b1, '{5'd0, 7'd0, 16'h0000}},
        '{'{REQ_MOVE, 8'h00, DIR_UP, 11'd0},       1'b1, '{5'd0, 7'd0, 16'h0000}},
        '{'{REQ_MOVE, 8'h00, DIR_LEFT, 11'd0},     1'b1, '{5'd0, 7'd0, 16'h0000}},
        '{'{REQ_PUT, 8'h41, DIR_UP, 11'd0},        1'b1, '{5'd0, 7'd1, 16'h0000}},
        '{'{REQ_READ, 8'h00, DIR_UP, 11'd0},       1'b1, '{5'd0, 7'd1, 16'h0741}},
        '{'{REQ_PUT, 8'hFF, DIR_UP, 11'd0},        1'b1, '{5'd0, 7'd2, 16'h0000}},
        '{'{REQ_PUT, 8'h00, DIR_UP, 11'd0},        1'b1, '{5'd0, 7'd3, 16'h0000}},
        '{'{REQ_PUT, CH_TAB, DIR_UP, 11'd0},       1'b1, '{5'd0, 7'd4, 16'h0000}},
        '{'{REQ_PUT, CH_TAB, DIR_UP, 11'd0},       1'b1, '{5'd0, 7'd8, 16'h0000}},
        '{'{REQ_PUT, CH_NL, DIR_UP, 11'd0},        1'b1, '{5'd1, 7'd0, 16'h0000}},
        '{'{REQ_PUT, CH_BS, DIR_UP, 11'd0},        1'b1, '{5'd0, 7'd79, 16'h0000}},
        '{'{REQ_READ, 8'h00, DIR_UP, 11'd79},      1'b1, '{5'd0, 7'd79, RESET_CELL}},
        '{'{REQ_MOVE, 8'h00, DIR_RIGHT, 11'd0},    1'b1, '{5'd0, 7'd79, 16'h0000}},
        '{'{REQ_PUT, CH_TAB, DIR_UP, 11'd0},       1'b0, '0},
        '{'{REQ_MOVE, 8'h00, DIR_DOWN, 11'd0},     1'b0, '0},
        '{'{REQ_READ, 8'h00, DIR_UP, 11'd1},       1'b0, '0},
        '{'{REQ_PUT, 8'h7E, DIR_UP, 11'd0},        1'b0, '0},
        '{'{REQ_READ, 8'h00, DIR_UP, 11'd2},       1'b0, '0}
    };

    text_terminal_char_engine DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void paint(logic [7:0] ch);
        int at;
        at = int'(cur_row) * COLUMNS + int'(cur_col);
        if (at < CELL_COUNT) begin
            screen_model[at] = {pen_color, ch};
        end
    endfunction

    function automatic void line_feed();
        if (int'(cur_row) + 1 >= ROWS) begin
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
                screen_model[i] = screen_model[i + COLUMNS];
            end
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
                screen_model[i] = {pen_color, CH_SPACE};
            end
            cur_row = ROW_LAST;
        end else begin
            cur_row = cur_row + 1'b1;
        end
    endfunction

    function automatic void step_col();
        if (int'(cur_col) + 1 >= COLUMNS) begin
            cur_col = '0;
            line_feed();
        end else begin
            cur_col = cur_col + 1'b1;
        end
    endfunction

    function automatic screen_reply_t apply_request(request_beat_t rq);
        screen_reply_t rp;
        int            pad;
        rp.data = '0;
        if (rq.kind == REQ_PUT) begin
            if (rq.ch == CH_NL) begin
                line_feed();
                cur_col = '0;
            end else if (rq.ch == CH_TAB) begin
                pad = TAB_STOP - int'(cur_col) % TAB_STOP;
                repeat (pad) begin
                    paint(CH_SPACE);
                    step_col();
                end
            end else if (rq.ch == CH_BS) begin
                if (cur_col != '0) begin
                    cur_col = cur_col - 1'b1;
                    paint(CH_SPACE);
                end else if (cur_row != '0) begin
                    cur_row = cur_row - 1'b1;
                    cur_col = COL_LAST;
                    paint(CH_SPACE);
                end
            end else begin
                paint(rq.ch);
                step_col();
            end
        end else if (rq.kind == REQ_MOVE) begin
            if (rq.dir == DIR_UP) begin
                if (cur_row != '0) cur_row = cur_row - 1'b1;
            end else if (rq.dir == DIR_DOWN) begin
                if (int'(cur_row) + 1 < ROWS) cur_row = cur_row + 1'b1;
            end else if (rq.dir == DIR_LEFT) begin
                if (cur_col != '0) cur_col = cur_col - 1'b1;
            end else begin
                if (int'(cur_col) + 1 < COLUMNS) cur_col = cur_col + 1'b1;
            end
        end else if (rq.kind == REQ_READ) begin
            if (int'(rq.idx) < CELL_COUNT) begin
                rp.data = screen_model[rq.idx];
            end
        end
        rp.row = cur_row;
        rp.col = cur_col;
        return rp;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic request_beat_t draw_request();
        request_beat_t rq;
        int            r;
        rq.ch  = 8'($urandom_range(0, 255));
        rq.dir = 2'($urandom_range(0, 3));
        rq.idx = 11'($urandom_range(0, 2047));
        r = $urandom_range(0, 99);
        if (r < 48) begin
            rq.kind = REQ_PUT;
            r = $urandom_range(0, 99);
            if (r < 12) rq.ch = CH_NL;
            else if (r < 20) rq.ch = CH_TAB;
            else if (r < 28) rq.ch = CH_BS;
        end else if (r < 68) begin
            rq.kind = REQ_MOVE;
        end else if (r < 94) begin
            rq.kind = REQ_READ;
            r = $urandom_range(0, 99);
            if (r < 45) rq.idx = 11'(int'(cur_row) * COLUMNS + $urandom_range(0, COLUMNS - 1));
            else if (r < 90) rq.idx = 11'($urandom_range(0, CELL_COUNT - 1));
        end else begin
            rq.kind = REQ_UNUSED;
        end
        return rq;
    endfunction

    task automatic send_request(request_beat_t rq, bit typed, screen_reply_t typed_reply);
        screen_reply_t predicted;
        int            gap;
        i_in_valid   <= 1'b1;
        i_req_type   <= rq.kind;
        i_char_code  <= rq.ch;
        i_move_dir   <= rq.dir;
        i_cell_index <= rq.idx;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_request(rq);
        pending_replies.push_back(typed ? typed_reply : predicted);
        items_sent++;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_color(logic [7:0] shade);
        i_cfg_valid  <= 1'b1;
        i_text_color <= shade;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pen_color = shade;
    endtask

    initial begin
        request_beat_t rq;
        int            count;
        logic [7:0]    shade;
        for (int i = 0; i < CELL_COUNT; i++) begin
            screen_model[i] = RESET_CELL;
        end
        cur_row   = '0;
        cur_col   = '0;
        pen_color = RESET_COLOR;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_color(RESET_COLOR);
        foreach (opening_steps[i]) begin
            send_request(opening_steps[i].rq, opening_steps[i].checked, opening_steps[i].reply);
        end
        for (int p = 0; p < N_PHASES; p++) begin
            drain_replies();
            case (p)
                0: shade = 8'h00;
                1: shade = 8'hFF;
                2: shade = 8'h1E;
                4: shade = 8'hF0;
                default: shade = 8'($urandom_range(0, 255));
            endcase
            write_color(shade);
            steady_flow = (p == 2);
            count = 0;
            while (count < PHASE_ITEMS) begin
                rq = draw_request();
                send_request(rq, 1'b0, '0);
                count++;
            end
        end
        drain_replies();
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // hold the sink off at random, and once long enough to back the block up
    initial begin
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && items_sent >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                stall_left = HOLD_TICKS;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!steady_flow) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        screen_reply_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result beat: cursor_row %0d cursor_col %0d cell_data %h",
                       o_cursor_row, o_cursor_col, o_cell_data);
                fault_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_cursor_row !== want.row) begin
                    $error("cursor_row: expected %0d, got %0d", want.row, o_cursor_row);
                    fault_count++;
                end
                if (o_cursor_col !== want.col) begin
                    $error("cursor_col: expected %0d, got %0d", want.col, o_cursor_col);
                    fault_count++;
                end
                if (o_cell_data !== want.data) begin
                    $error("cell_data: expected %h, got %h", want.data, o_cell_data);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        #15_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/ttce_pkg.sv
hdl/ttce_ram.sv
hdl/text_terminal_char_engine.sv
tb/text_terminal_char_engine_tb.sv
